// ===== src/shtc_pkg.sv =====
// Package for the syntax highlight token classifier.
// Holds the channel payload types, highlight classes, the front-to-back command
// control type, the fixed word lists and the byte test functions.
`default_nettype none

package shtc_pkg;

   localparam logic [2:0] CLS_TEXT    = 3'd0;
   localparam logic [2:0] CLS_COMMENT = 3'd1;
   localparam logic [2:0] CLS_STRING  = 3'd2;
   localparam logic [2:0] CLS_NUMBER  = 3'd3;
   localparam logic [2:0] CLS_KEYWORD = 3'd4;
   localparam logic [2:0] CLS_SECTION = 3'd5;
   localparam logic [2:0] CLS_CLASS   = 3'd6;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;

   // Two class names of the word list, as ASCII bytes with the first byte at the top.
   localparam logic [79:0] WORD_SCOPED_REFS = 80'h6c6f_6361_6c5f_7265_6673;
   localparam logic [63:0] WORD_LIMIT_REFS  = 64'h6d69_6e5f_7265_6673;

   typedef struct packed {
      logic [7:0] character;
      logic       text_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_character;
      logic [2:0] highlight_class;
      logic       run_last;
      logic       final_byte;
   } rsp_type;

   typedef struct packed {
      logic       classify;
      logic       has_single;
      logic [7:0] single_char;
      logic [2:0] single_cls;
      logic       final_item;
   } cmd_ctrl_type;

   localparam int KW_COUNT = 25;
   localparam int KW_CHARS = 10;

   // Entries are left aligned and padded with spaces, which never occur in a word.
   localparam logic [KW_CHARS*8-1:0] KW_TEXT [KW_COUNT] = '{
      "if        ", "else      ", "while     ", "requires  ", "this      ",
      "other     ", "type      ", "false     ", "true      ", "set       ",
      "see       ", "mod       ", "act       ", "do        ", "refs      ",
      WORD_SCOPED_REFS, {WORD_LIMIT_REFS, "  "}, "env       ", "int       ", "bool      ",
      "real      ", "point     ", "text      ", "vector    ", "box       "
   };

   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd2, 4'd4, 4'd5, 4'd8, 4'd4, 4'd5, 4'd4, 4'd5, 4'd4, 4'd3,
      4'd3, 4'd3, 4'd3, 4'd2, 4'd4, 4'd10, 4'd8, 4'd3, 4'd3, 4'd4,
      4'd4, 4'd5, 4'd4, 4'd6, 4'd3
   };

   localparam logic [2:0] KW_CLS [KW_COUNT] = '{
      CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD,
      CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_SECTION,
      CLS_SECTION, CLS_SECTION, CLS_SECTION, CLS_SECTION, CLS_CLASS,
      CLS_CLASS, CLS_CLASS, CLS_CLASS, CLS_CLASS, CLS_CLASS,
      CLS_CLASS, CLS_CLASS, CLS_CLASS, CLS_CLASS, CLS_CLASS
   };

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= "0") && (ch <= "9");
   endfunction

   function automatic logic is_sep(input logic [7:0] ch);
      logic sep;
      case (ch)
         ",", ".", "-", "+", "/", "*", "=", "<", ">", "(", ")", "{", "}",
         "[", "]", ";", ":", "&", "|", "~", " ",
         CH_HASH, CH_DOLLAR, CH_TAB, CH_LF, CH_CR: sep = 1'b1;
         default: sep = 1'b0;
      endcase
      return sep;
   endfunction

   // The first entry whose text and length match wins; no match is plain text.
   function automatic logic [2:0] kw_lookup(input logic [KW_CHARS*8-1:0] word,
                                            input logic [4:0] len);
      logic [2:0] cls;
      logic       hit;
      cls = CLS_TEXT;
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         hit = (len == {1'b0, KW_LEN[i]});
         for (int k = 0; k < KW_CHARS; k++) begin
            if ((k < int'(KW_LEN[i])) &&
                (word[k*8 +: 8] != KW_TEXT[i][(KW_CHARS-1-k)*8 +: 8])) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            cls = KW_CLS[i];
         end
      end
      return cls;
   endfunction

endpackage

`default_nettype wire

// ===== src/syntax_highlight_token_classifier_top.sv =====
// Top level of the syntax highlight token classifier.
// Instantiates shtc_front, shtc_queue and shtc_back; depends on shtc_pkg.
//
// The block takes one text byte per transfer and returns every byte, in order, with
// its highlight class. The front accepts one byte per cycle while the two-entry
// command queue has room and holds word bytes (up to MAX_WORD) until the word ends;
// a byte that closes a word or causes a result becomes one command in the queue.
// With the block idle, the first result of a byte passes through the queue entry, the
// back's command registers and the output register before it is valid. The back drives
// one result per cycle while the output is taken, with no gap between commands. A word
// of n bytes ended by a separator bursts n + 1 results, at most MAX_WORD + 1, and once
// the queue fills the input stalls until the burst drains.
`default_nettype none

module syntax_highlight_token_classifier_top
   import shtc_pkg::*;
#(
   parameter int MAX_WORD = 10
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int LEN_W = $clog2(MAX_WORD + 1);
   localparam int IDX_W = $clog2(MAX_WORD);
   localparam int Q_W   = $bits(cmd_ctrl_type) + LEN_W + MAX_WORD * 8;

   logic                     q_full;
   logic                     q_push;
   logic                     q_pop;
   logic                     q_valid;
   cmd_ctrl_type             cmd_ctrl;
   logic [LEN_W-1:0]         cmd_len;
   logic [MAX_WORD-1:0][7:0] cmd_word;
   cmd_ctrl_type             head_ctrl;
   logic [LEN_W-1:0]         head_len;
   logic [MAX_WORD-1:0][7:0] head_word;
   logic [Q_W-1:0]           q_in;
   logic [Q_W-1:0]           q_out;

   assign q_in = {cmd_ctrl, cmd_len, cmd_word};
   assign {head_ctrl, head_len, head_word} = q_out;

   shtc_front #(
      .MAX_WORD (MAX_WORD),
      .LEN_W    (LEN_W),
      .IDX_W    (IDX_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .cmd_ctrl  (cmd_ctrl),
      .cmd_len   (cmd_len),
      .cmd_word  (cmd_word)
   );

   shtc_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .not_empty (q_valid)
   );

   shtc_back #(
      .MAX_WORD (MAX_WORD),
      .LEN_W    (LEN_W),
      .IDX_W    (IDX_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_ctrl    (head_ctrl),
      .q_len     (head_len),
      .q_word    (head_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== src/shtc_front.sv =====
// Front end of the token classifier: scan state, word buffer and command build.
// Accepts one byte per cycle while the queue has room; writes one command per byte that causes results.
// Depends on shtc_pkg.
`default_nettype none

module shtc_front
   import shtc_pkg::*;
#(
   parameter int MAX_WORD = 10,
   parameter int LEN_W    = $clog2(MAX_WORD + 1),
   parameter int IDX_W    = $clog2(MAX_WORD)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire req_type                      req_data,
   input  wire logic                         q_full,
   output logic                              q_push,
   output cmd_ctrl_type                      cmd_ctrl,
   output logic [LEN_W-1:0]                  cmd_len,
   output logic [MAX_WORD-1:0][7:0]          cmd_word
);

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_DOLLAR = 3'd1;
   localparam logic [2:0] MODE_HASH   = 3'd2;
   localparam logic [2:0] MODE_STRING = 3'd3;
   localparam logic [2:0] MODE_NUMBER = 3'd4;
   localparam logic [2:0] MODE_WORD   = 3'd5;
   localparam logic [2:0] MODE_LONG   = 3'd6;

   logic [2:0]               mode_ff, mode_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [MAX_WORD-1:0][7:0] buf_ff, buf_in;
   logic                     accept;
   logic [7:0]               ch;
   logic                     sep;
   logic                     fresh;
   logic [2:0]               fresh_cls;
   logic [2:0]               fresh_mode;
   logic                     fresh_word;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;
   assign ch        = req_data.character;
   assign sep       = is_sep(ch);

   always_comb begin
      fresh_word = 1'b0;
      fresh_cls  = CLS_TEXT;
      fresh_mode = MODE_IDLE;
      priority if (ch == CH_DOLLAR) begin
         fresh_cls  = CLS_COMMENT;
         fresh_mode = MODE_DOLLAR;
      end else if (ch == CH_HASH) begin
         fresh_cls  = CLS_COMMENT;
         fresh_mode = MODE_HASH;
      end else if (ch == CH_QUOTE) begin
         fresh_cls  = CLS_STRING;
         fresh_mode = MODE_STRING;
      end else if (is_digit(ch)) begin
         fresh_cls  = CLS_NUMBER;
         fresh_mode = MODE_NUMBER;
      end else if (sep) begin
         fresh_cls  = CLS_TEXT;
         fresh_mode = MODE_IDLE;
      end else begin
         fresh_word = 1'b1;
         fresh_mode = MODE_WORD;
      end
   end

   always_comb begin
      mode_in              = mode_ff;
      len_in               = len_ff;
      buf_in               = buf_ff;
      fresh                = 1'b0;
      cmd_len              = '0;
      cmd_ctrl.classify    = 1'b0;
      cmd_ctrl.has_single  = 1'b0;
      cmd_ctrl.single_char = ch;
      cmd_ctrl.single_cls  = CLS_TEXT;
      cmd_ctrl.final_item  = req_data.text_end;

      unique case (mode_ff)
         MODE_DOLLAR: begin
            cmd_ctrl.has_single = 1'b1;
            cmd_ctrl.single_cls = CLS_COMMENT;
            if (ch == CH_DOLLAR) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_HASH: begin
            if (ch == CH_LF) begin
               fresh = 1'b1;
            end else begin
               cmd_ctrl.has_single = 1'b1;
               cmd_ctrl.single_cls = CLS_COMMENT;
            end
         end
         MODE_STRING: begin
            cmd_ctrl.has_single = 1'b1;
            cmd_ctrl.single_cls = CLS_STRING;
            if (ch == CH_QUOTE) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_NUMBER: begin
            if (is_digit(ch)) begin
               cmd_ctrl.has_single = 1'b1;
               cmd_ctrl.single_cls = CLS_NUMBER;
            end else begin
               fresh = 1'b1;
            end
         end
         MODE_WORD: begin
            if (sep) begin
               cmd_len           = len_ff;
               cmd_ctrl.classify = 1'b1;
               len_in            = '0;
               fresh             = 1'b1;
            end else if (len_ff < LEN_W'(MAX_WORD)) begin
               buf_in[len_ff[IDX_W-1:0]] = ch;
               len_in                    = LEN_W'(len_ff + 1'b1);
            end else begin
               cmd_len             = len_ff;
               cmd_ctrl.has_single = 1'b1;
               len_in              = '0;
               mode_in             = MODE_LONG;
            end
         end
         MODE_LONG: begin
            if (sep) begin
               fresh = 1'b1;
            end else begin
               cmd_ctrl.has_single = 1'b1;
            end
         end
         default: begin
            fresh = 1'b1;
         end
      endcase

      if (fresh) begin
         mode_in = fresh_mode;
         if (fresh_word) begin
            buf_in[0] = ch;
            len_in    = LEN_W'(1);
         end else begin
            cmd_ctrl.has_single = 1'b1;
            cmd_ctrl.single_cls = fresh_cls;
         end
      end

      if (req_data.text_end) begin
         if (mode_in == MODE_WORD) begin
            cmd_len           = len_in;
            cmd_ctrl.classify = 1'b1;
         end
         mode_in = MODE_IDLE;
         len_in  = '0;
      end
   end

   assign cmd_word = buf_in;
   assign q_push   = accept && ((cmd_len != '0) || cmd_ctrl.has_single);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         len_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         buf_ff <= buf_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/shtc_queue.sv =====
// Two-entry command queue between the front and back of the token classifier.
// Generic over the entry width; depends on nothing else.
`default_nettype none

module shtc_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  not_empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== src/shtc_back.sv =====
// Back end of the token classifier: takes commands from the queue, looks up the
// word class, and drives one result per cycle into the output register while the output is taken.
// Depends on shtc_pkg.
`default_nettype none

module shtc_back
   import shtc_pkg::*;
#(
   parameter int MAX_WORD = 10,
   parameter int LEN_W    = $clog2(MAX_WORD + 1),
   parameter int IDX_W    = $clog2(MAX_WORD)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_valid,
   output logic                         q_pop,
   input  wire cmd_ctrl_type            q_ctrl,
   input  wire logic [LEN_W-1:0]        q_len,
   input  wire logic [MAX_WORD-1:0][7:0] q_word,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output rsp_type                      rsp_data
);

   logic                     active_ff, active_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]         idx_ff, idx_in;
   logic [LEN_W-1:0]         len_ff;
   logic [MAX_WORD-1:0][7:0] word_ff;
   logic [2:0]               cls_ff;
   cmd_ctrl_type             ctrl_ff;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic                     emit;
   logic                     emit_last;
   logic                     in_word;
   logic [2:0]               lookup_cls;

   assign emit       = active_ff && (!rsp_valid_ff || rsp_ready);
   assign in_word    = (idx_ff < len_ff);
   assign emit_last  = in_word ? ((LEN_W'(idx_ff + 1'b1) == len_ff) && !ctrl_ff.has_single)
                               : 1'b1;
   assign q_pop      = q_valid && (!active_ff || (emit && emit_last));
   assign lookup_cls = kw_lookup(q_word[KW_CHARS-1:0], 5'(q_len));

   always_comb begin
      rsp_data_in.out_character   = in_word ? word_ff[idx_ff[IDX_W-1:0]] : ctrl_ff.single_char;
      rsp_data_in.highlight_class = in_word ? cls_ff : ctrl_ff.single_cls;
      rsp_data_in.run_last        = emit_last;
      rsp_data_in.final_byte      = emit_last && ctrl_ff.final_item;

      active_in = active_ff;
      idx_in    = idx_ff;
      if (q_pop) begin
         active_in = 1'b1;
         idx_in    = '0;
      end else if (emit) begin
         if (emit_last) begin
            active_in = 1'b0;
         end else begin
            idx_in = LEN_W'(idx_ff + 1'b1);
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         word_ff <= q_word;
         len_ff  <= q_len;
         ctrl_ff <= q_ctrl;
         cls_ff  <= q_ctrl.classify ? lookup_cls : CLS_TEXT;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
